### design/dwp_pkg.sv
// ----------------------------------------------------------------------------
// dwp_pkg: shared types and constants for the dual-wheel PID regulator
// Word formats, direction codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package dwp_pkg;

	localparam int unsigned DUTY_MAX_DEF = 1000;

	localparam int unsigned SPEED_W = 12;
	localparam int unsigned GAIN_W  = 16;
	localparam int unsigned DUTY_W  = 10;
	localparam int unsigned ADDR_W  = 4;
	localparam int unsigned DATA_W  = 32;

	localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 16'd3328;
	localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 16'd256;
	localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 16'd256;

	localparam logic [1:0] REG_GAIN_PROP  = 2'd0;
	localparam logic [1:0] REG_GAIN_INTEG = 2'd1;
	localparam logic [1:0] REG_GAIN_DERIV = 2'd2;

	localparam logic OP_SET  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

	typedef struct packed {
		logic                      op;
		logic signed [SPEED_W-1:0] left_speed;
		logic signed [SPEED_W-1:0] right_speed;
	} cmd_word_t;

	typedef struct packed {
		logic [DUTY_W-1:0] left_duty;
		logic [DUTY_W-1:0] right_duty;
		dir_t              left_dir;
		dir_t              right_dir;
	} res_word_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop;
		logic [GAIN_W-1:0] integ;
		logic [GAIN_W-1:0] deriv;
	} gains_t;

endpackage

`default_nettype wire

### design/dwp_wheel.sv
// ----------------------------------------------------------------------------
// dwp_wheel: one wheel of the regulator
// Holds the setpoint, duty and error history of one wheel and computes the
// next duty and bridge direction for a set or tick word in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dwp_wheel #(
	parameter int unsigned DUTY_MAX = dwp_pkg::DUTY_MAX_DEF,
	parameter int unsigned DW       = $clog2(DUTY_MAX + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              load,
	input  wire logic                              op,
	input  wire logic signed [dwp_pkg::SPEED_W-1:0] speed,
	input  wire dwp_pkg::gains_t                   gains,
	output logic [DW-1:0]                          duty_next,
	output dwp_pkg::dir_t                          dir_next
);
	import dwp_pkg::*;

	localparam int unsigned AW = 35;
	localparam int unsigned FW = AW - 8;
	localparam logic signed [FW-1:0] DMAX_F = FW'(DUTY_MAX);

	logic signed [SPEED_W-1:0] sp_q;
	logic [DW-1:0]             duty_q;
	logic signed [12:0]        e1_q;
	logic signed [12:0]        e2_q;

	logic signed [12:0] sp_x, meas_x, mag_sp, mag_meas, err;
	logic [31:0]        twice;
	logic [DW-1:0]      set_duty, tick_duty;
	logic signed [13:0] d1;
	logic signed [14:0] d2;
	logic signed [16:0] gp_s, gi_s, gd_s;
	logic signed [30:0] p_prop;
	logic signed [29:0] p_integ;
	logic signed [31:0] p_deriv;
	logic signed [AW-1:0] acc;
	logic signed [FW-1:0] fl;
	logic signed [SPEED_W-1:0] sp_new;

	always_comb begin
		sp_x     = 13'(sp_q);
		meas_x   = 13'(speed);
		mag_sp   = sp_x[12] ? -sp_x : sp_x;
		mag_meas = meas_x[12] ? -meas_x : meas_x;
		err      = mag_sp - mag_meas;

		twice = {18'd0, mag_meas[12:0], 1'b0} > 32'(DUTY_MAX) ? 32'(DUTY_MAX)
			: {18'd0, mag_meas[12:0], 1'b0};
		set_duty = DW'(twice);

		d1   = 14'(err) - 14'(e1_q);
		d2   = 15'(err) - (15'(e1_q) <<< 1) + 15'(e2_q);
		gp_s = $signed({1'b0, gains.prop});
		gi_s = $signed({1'b0, gains.integ});
		gd_s = $signed({1'b0, gains.deriv});
		p_prop  = gp_s * d1;
		p_integ = gi_s * err;
		p_deriv = gd_s * d2;
		acc = AW'($signed({1'b0, duty_q, 8'd0})) + AW'(p_prop) + AW'(p_integ)
			+ AW'(p_deriv);
		fl = acc[AW-1:8];
		if (fl <= 0) begin
			tick_duty = '0;
		end else if (fl >= DMAX_F) begin
			tick_duty = DW'(DUTY_MAX);
		end else begin
			tick_duty = DW'(fl);
		end

		sp_new    = (op == OP_SET) ? speed : sp_q;
		duty_next = (op == OP_SET) ? set_duty : tick_duty;
		if (sp_new == '0) begin
			dir_next = DIR_STOP;
		end else if (sp_new[SPEED_W-1]) begin
			dir_next = DIR_REV;
		end else begin
			dir_next = DIR_FWD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q   <= '0;
			duty_q <= '0;
			e1_q   <= '0;
			e2_q   <= '0;
		end else if (load) begin
			duty_q <= duty_next;
			if (op == OP_SET) begin
				sp_q <= speed;
			end else begin
				e1_q <= err;
				e2_q <= e1_q;
			end
		end
	end

endmodule

`default_nettype wire

### design/dual_wheel_incremental_pid_pwm_top.sv
// ----------------------------------------------------------------------------
// dual_wheel_incremental_pid_pwm_top: two-wheel incremental PID regulator
// Set words load setpoints and open-loop duties; tick words run the PID step
// on both wheels and return new PWM duties and bridge directions.
//
//   channel  signals                           word
//   cmd      cmd_valid, cmd_stall, cmd_word    op, left_speed, right_speed
//   res      res_valid, res_stall, res_word    duties and directions
//   apb      psel, penable, pwrite, paddr ...  gain registers
//
// A word is registered on entry and its result is registered once it can move forward.
// A new word is taken every cycle while res is free.
// The wheel multipliers and adder sit between the entry and result registers.
// Reset clears the gains to defaults and all wheel state to zero.
// A stalled result holds; the entry register stalls only when it is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_wheel_incremental_pid_pwm_top #(
	parameter int unsigned DUTY_MAX = dwp_pkg::DUTY_MAX_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cmd_valid,
	output logic                              cmd_stall,
	input  wire dwp_pkg::cmd_word_t           cmd_word,
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output dwp_pkg::res_word_t                res_word,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [dwp_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [dwp_pkg::DATA_W-1:0]   pwdata,
	output logic [dwp_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);
	import dwp_pkg::*;

	localparam int unsigned DW = $clog2(DUTY_MAX + 1);

	gains_t    gains_q;
	cmd_word_t cmd_s1;
	logic      valid_s1;
	res_word_t res_q;
	logic      res_valid_q;
	logic      advance;
	logic      cfg_wr;
	logic [DW-1:0] l_duty, r_duty;
	dir_t      l_dir, r_dir;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign res_valid = res_valid_q;
	assign res_word  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.prop  <= GAIN_PROP_RST;
			gains_q.integ <= GAIN_INTEG_RST;
			gains_q.deriv <= GAIN_DERIV_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_GAIN_PROP:  gains_q.prop  <= pwdata[GAIN_W-1:0];
				REG_GAIN_INTEG: gains_q.integ <= pwdata[GAIN_W-1:0];
				REG_GAIN_DERIV: gains_q.deriv <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_GAIN_PROP:  prdata = DATA_W'(gains_q.prop);
			REG_GAIN_INTEG: prdata = DATA_W'(gains_q.integ);
			REG_GAIN_DERIV: prdata = DATA_W'(gains_q.deriv);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd_word;
		end
	end

	dwp_wheel #(.DUTY_MAX(DUTY_MAX), .DW(DW)) u_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.op        (cmd_s1.op),
		.speed     (cmd_s1.left_speed),
		.gains     (gains_q),
		.duty_next (l_duty),
		.dir_next  (l_dir)
	);

	dwp_wheel #(.DUTY_MAX(DUTY_MAX), .DW(DW)) u_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.op        (cmd_s1.op),
		.speed     (cmd_s1.right_speed),
		.gains     (gains_q),
		.duty_next (r_duty),
		.dir_next  (r_dir)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.left_duty  <= DUTY_W'(l_duty);
			res_q.right_duty <= DUTY_W'(r_duty);
			res_q.left_dir   <= l_dir;
			res_q.right_dir  <= r_dir;
		end
	end

	a_idle_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !cmd_stall)
		else $error("Input stalled with an empty entry register.");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("Result register empty after a word moved forward.");

	a_stall_keeps_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("Entry word lost while the result side was stalled.");

	a_duty_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (DUTY_MAX > 1023) ||
			(res_q.left_duty <= DUTY_MAX && res_q.right_duty <= DUTY_MAX))
		else $error("Duty above the configured maximum.");

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for dual_wheel_incremental_pid_pwm_top
// A short table of set and tick words runs first. Some rows carry a typed
// expected drive; the rest are checked against a behavioral copy of the
// regulator kept in the bench. Several phases of random words follow under
// different gain settings, from all-zero to all-ones. The gains are written
// and read back over the register port while the regulator is idle. Both
// channels idle at random, and the result side holds off for long stretches
// so the regulator backs up into its command input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import dwp_pkg::*;

	localparam int DUTY_LIM = int'(DUTY_MAX_DEF);
	localparam int CYCLE_LIMIT = 100000;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 104;
	localparam int HOLD_CYCLES = 40;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic signed [SPEED_W-1:0] SPD_MAX = 12'sh7ff;
	localparam logic signed [SPEED_W-1:0] SPD_MIN = 12'sh800;

	typedef struct {
		logic signed [SPEED_W-1:0] setpoint;
		int                        duty;
		int                        err1;
		int                        err2;
	} wheel_state_t;

	typedef struct packed {
		cmd_word_t cmd;
		logic      known;
		res_word_t drive;
	} cmd_row_t;

	localparam res_word_t UNTYPED = '0;

	localparam cmd_row_t DIRECTED_ROWS [22] = '{
		'{'{OP_TICK, 12'sd0, 12'sd0}, 1'b1, '{10'd0, 10'd0, DIR_STOP, DIR_STOP}},
		'{'{OP_TICK, SPD_MAX, SPD_MIN}, 1'b1, '{10'd0, 10'd0, DIR_STOP, DIR_STOP}},
		'{'{OP_SET, SPD_MAX, SPD_MIN}, 1'b1, '{10'd1000, 10'd1000, DIR_FWD, DIR_REV}},
		'{'{OP_TICK, 12'sd0, 12'sd0}, 1'b0, UNTYPED},
		'{'{OP_TICK, SPD_MAX, SPD_MIN}, 1'b0, UNTYPED},
		'{'{OP_TICK, SPD_MIN, SPD_MAX}, 1'b0, UNTYPED},
		'{'{OP_SET, 12'sd1, -12'sd1}, 1'b1, '{10'd2, 10'd2, DIR_FWD, DIR_REV}},
		'{'{OP_TICK, 12'sd0, 12'sd0}, 1'b0, UNTYPED},
		'{'{OP_TICK, 12'sd1, -12'sd1}, 1'b0, UNTYPED},
		'{'{OP_SET, -12'sd1, 12'sd1}, 1'b1, '{10'd2, 10'd2, DIR_REV, DIR_FWD}},
		'{'{OP_TICK, -12'sd1, 12'sd0}, 1'b0, UNTYPED},
		'{'{OP_SET, 12'sd0, 12'sd0}, 1'b1, '{10'd0, 10'd0, DIR_STOP, DIR_STOP}},
		'{'{OP_TICK, 12'sd5, -12'sd5}, 1'b0, UNTYPED},
		'{'{OP_SET, 12'sd300, -12'sd250}, 1'b1, '{10'd600, 10'd500, DIR_FWD, DIR_REV}},
		'{'{OP_TICK, 12'sd280, -12'sd260}, 1'b0, UNTYPED},
		'{'{OP_TICK, 12'sd310, -12'sd240}, 1'b0, UNTYPED},
		'{'{OP_TICK, 12'sd300, -12'sd250}, 1'b0, UNTYPED},
		'{'{OP_SET, 12'sd499, -12'sd500}, 1'b1, '{10'd998, 10'd1000, DIR_FWD, DIR_REV}},
		'{'{OP_SET, 12'sd500, 12'sd500}, 1'b1, '{10'd1000, 10'd1000, DIR_FWD, DIR_FWD}},
		'{'{OP_TICK, SPD_MIN, SPD_MIN}, 1'b0, UNTYPED},
		'{'{OP_TICK, 12'sd1024, 12'sd1024}, 1'b0, UNTYPED},
		'{'{OP_SET, -12'sd1024, 12'sd1024}, 1'b1, '{10'd1000, 10'd1000, DIR_REV, DIR_FWD}}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	cmd_word_t           cmd_word = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	res_word_t           res_word;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	gains_t       gain_now;
	wheel_state_t left_wheel;
	wheel_state_t right_wheel;
	res_word_t    pending_drive_q [$];
	int           fail_count = 0;
	int           words_sent = 0;
	int           drives_taken = 0;
	int           cycle_count = 0;

	dual_wheel_incremental_pid_pwm_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd_word    (cmd_word),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_word    (res_word),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("dual_wheel_incremental_pid_pwm_top verification failed");
			$finish;
		end
	end

	function automatic longint speed_mag(logic signed [SPEED_W-1:0] s);
		longint v;
		v = s;
		return (v < 0) ? -v : v;
	endfunction

	function automatic int clamp_duty(longint v);
		if (v <= 0)
			return 0;
		if (v >= DUTY_LIM)
			return DUTY_LIM;
		return int'(v);
	endfunction

	function automatic dir_t dir_of(logic signed [SPEED_W-1:0] sp);
		if (sp == 0)
			return DIR_STOP;
		return (sp > 0) ? DIR_FWD : DIR_REV;
	endfunction

	function automatic wheel_state_t wheel_after_set(wheel_state_t w,
			logic signed [SPEED_W-1:0] sp);
		w.setpoint = sp;
		w.duty = (sp == 0) ? 0 : clamp_duty(2 * speed_mag(sp));
		return w;
	endfunction

	// Incremental PID step in Q8.8; the arithmetic shift floors toward minus infinity.
	function automatic wheel_state_t wheel_after_tick(wheel_state_t w,
			logic signed [SPEED_W-1:0] meas);
		longint err;
		longint acc;
		err = speed_mag(w.setpoint) - speed_mag(meas);
		acc = longint'(w.duty) * 256
			+ longint'(gain_now.prop) * (err - w.err1)
			+ longint'(gain_now.integ) * err
			+ longint'(gain_now.deriv) * (err - 2 * w.err1 + w.err2);
		w.duty = clamp_duty(acc >>> 8);
		w.err2 = w.err1;
		w.err1 = int'(err);
		return w;
	endfunction

	function automatic res_word_t next_drive(cmd_word_t w);
		res_word_t r;
		if (w.op == OP_SET) begin
			left_wheel = wheel_after_set(left_wheel, w.left_speed);
			right_wheel = wheel_after_set(right_wheel, w.right_speed);
		end else begin
			left_wheel = wheel_after_tick(left_wheel, w.left_speed);
			right_wheel = wheel_after_tick(right_wheel, w.right_speed);
		end
		r.left_duty = left_wheel.duty[DUTY_W-1:0];
		r.right_duty = right_wheel.duty[DUTY_W-1:0];
		r.left_dir = dir_of(left_wheel.setpoint);
		r.right_dir = dir_of(right_wheel.setpoint);
		return r;
	endfunction

	function automatic logic signed [SPEED_W-1:0] pick_setpoint();
		int v;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = ($urandom_range(0, 1) != 0) ? 2047 : -2048;
			2, 3: v = int'($urandom_range(0, 1000)) - 500;
			default: v = int'($urandom_range(0, 4095)) - 2048;
		endcase
		return v[SPEED_W-1:0];
	endfunction

	// Most ticks report a speed close to the setpoint so the loop settles.
	function automatic logic signed [SPEED_W-1:0] pick_measure(logic signed [SPEED_W-1:0] sp);
		int v;
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			v = int'(sp) + int'($urandom_range(0, 60)) - 30;
		else if (r < 70)
			v = -int'(sp) + int'($urandom_range(0, 20)) - 10;
		else if (r < 88)
			v = int'($urandom_range(0, 4095)) - 2048;
		else
			v = ($urandom_range(0, 1) != 0) ? 2047 : -2048;
		if (v > 2047)
			v = 2047;
		if (v < -2048)
			v = -2048;
		return v[SPEED_W-1:0];
	endfunction

	function automatic cmd_word_t random_cmd();
		cmd_word_t w;
		if ($urandom_range(0, 99) < 15) begin
			w.op = OP_SET;
			w.left_speed = pick_setpoint();
			w.right_speed = pick_setpoint();
		end else begin
			w.op = OP_TICK;
			w.left_speed = pick_measure(left_wheel.setpoint);
			w.right_speed = pick_measure(right_wheel.setpoint);
		end
		return w;
	endfunction

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	task automatic send_cmd(input cmd_word_t w, input logic known, input res_word_t typed);
		int gap;
		res_word_t predicted;
		gap = ((words_sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word <= w;
		do @(posedge clk); while (cmd_stall);
		words_sent++;
		predicted = next_drive(w);
		pending_drive_q.push_back(known ? typed : predicted);
	endtask

	task automatic write_gain(input logic [1:0] idx, input logic [GAIN_W-1:0] value);
		logic [DATA_W-1:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_GAIN_PROP: gain_now.prop = value;
			REG_GAIN_INTEG: gain_now.integ = value;
			REG_GAIN_DERIV: gain_now.deriv = value;
			default: ;
		endcase
		if (idx != REG_UNUSED)
			compare_field("gain readback", value, rd[GAIN_W-1:0]);
	endtask

	task automatic wait_drained();
		while (pending_drive_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		gains_t phase_gains [PHASES];
		cmd_row_t row;
		gain_now = '{prop: GAIN_PROP_RST, integ: GAIN_INTEG_RST, deriv: GAIN_DERIV_RST};
		left_wheel = '{default: 0};
		right_wheel = '{default: 0};
		phase_gains[0] = '{16'hffff, 16'hffff, 16'hffff};
		phase_gains[1] = '{16'd0, 16'd0, 16'd0};
		phase_gains[2] = '{16'd256, 16'd0, 16'd0};
		phase_gains[3] = '{16'd0, 16'd1, 16'd0};
		phase_gains[4] = '{GAIN_PROP_RST, GAIN_INTEG_RST, GAIN_DERIV_RST};
		phase_gains[5] = '{16'($urandom_range(0, 4095)), 16'($urandom_range(0, 1023)),
			16'($urandom_range(0, 1023))};
		phase_gains[6] = '{16'($urandom_range(0, 1023)), 16'($urandom_range(0, 255)),
			16'($urandom_range(0, 65535))};
		phase_gains[7] = '{16'($urandom), 16'($urandom), 16'($urandom)};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
			row = DIRECTED_ROWS[i];
			send_cmd(row.cmd, row.known, row.drive);
		end
		cmd_valid <= 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			write_gain(REG_GAIN_PROP, phase_gains[p].prop);
			@(posedge clk);
			write_gain(REG_GAIN_INTEG, phase_gains[p].integ);
			@(posedge clk);
			write_gain(REG_GAIN_DERIV, phase_gains[p].deriv);
			@(posedge clk);
			if (p == 2) begin
				write_gain(REG_UNUSED, 16'($urandom));
				@(posedge clk);
			end
			for (int n = 0; n < PHASE_WORDS; n++)
				send_cmd(random_cmd(), 1'b0, UNTYPED);
			cmd_valid <= 1'b0;
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("dual_wheel_incremental_pid_pwm_top verification clean");
		else
			$display("dual_wheel_incremental_pid_pwm_top verification failed");
		$finish;
	end

	initial begin
		res_word_t want;
		int hold;
		@(posedge arst_n);
		forever begin
			if (drives_taken == 200 || drives_taken == 520)
				hold = HOLD_CYCLES;
			else if ((drives_taken / 45) % 4 == 1)
				hold = 0;
			else
				hold = $urandom_range(0, 3);
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
			drives_taken++;
			if (pending_drive_q.size() == 0) begin
				$display("%0t: result word with nothing pending, got %p", $time, res_word);
				fail_count++;
			end else begin
				want = pending_drive_q.pop_front();
				compare_field("left_duty", want.left_duty, res_word.left_duty);
				compare_field("right_duty", want.right_duty, res_word.right_duty);
				compare_field("left_dir", want.left_dir, res_word.left_dir);
				compare_field("right_dir", want.right_dir, res_word.right_dir);
			end
		end
	end

endmodule
